FILE: hw/rtl/rtpv_pkg.sv
// Shared types and constants for the RTP flow header validator.
package rtpv_pkg;

  localparam logic [15:0] MIN_HEADER_LEN = 16'd12;
  localparam logic [1:0]  MAX_VERSION    = 2'd2;

  localparam logic [6:0] MAX_PT_RESET    = 7'd34;
  localparam logic [7:0] NEEDED_RESET    = 8'd3;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_TYPE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PACKETS_NEEDED   = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    VERDICT_IN_PROCESS = 2'd0,
    VERDICT_INVALID    = 2'd1,
    VERDICT_RTP        = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [15:0] packet_length;
    logic        from_initiator;
    logic [1:0]  rtp_version;
    logic [6:0]  payload_kind;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
  } header_t;

  typedef struct packed {
    logic [6:0] max_payload_type;
    logic [7:0] packets_needed;
  } cfg_t;

  typedef struct packed {
    logic [15:0] seq_last;
    logic [31:0] time_last;
    logic [31:0] source;
    logic [7:0]  packets;
  } dir_state_t;

endpackage

FILE: hw/rtl/rtpv_hdr_if.sv
// Decoded packet header channel.
interface rtpv_hdr_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_length;
  logic        from_initiator;
  logic [1:0]  rtp_version;
  logic [6:0]  payload_kind;
  logic [15:0] sequence_number;
  logic [31:0] time_stamp;
  logic [31:0] source_id;

  modport source (
    output valid, packet_length, from_initiator, rtp_version, payload_kind,
           sequence_number, time_stamp, source_id,
    input  ready
  );
  modport sink (
    input  valid, packet_length, from_initiator, rtp_version, payload_kind,
           sequence_number, time_stamp, source_id,
    output ready
  );
endinterface

FILE: hw/rtl/rtpv_res_if.sv
// Verdict result channel.
interface rtpv_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

FILE: hw/rtl/rtpv_cfg_if.sv
// Configuration register write channel.
interface rtpv_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rtpv_flow.sv
// Per-direction flow state and verdict logic for one header per cycle while advance is high.
module rtpv_flow import rtpv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  header_t  hdr,
  input  cfg_t     cfg,
  output verdict_t verdict
);

  logic       continuing;
  logic       continuing_next;
  dir_state_t dir_state [2];
  dir_state_t cur;
  dir_state_t cur_next;
  logic [15:0] seq_inc;
  logic [7:0]  count_inc;
  logic        bad_header;
  logic        mismatch;

  assign cur       = dir_state[hdr.from_initiator];
  assign seq_inc   = cur.seq_last + 16'd1;
  assign count_inc = cur.packets + 8'd1;

  assign bad_header = (hdr.packet_length < MIN_HEADER_LEN) ||
                      (hdr.rtp_version > MAX_VERSION) ||
                      (hdr.payload_kind > cfg.max_payload_type);
  assign mismatch   = (hdr.sequence_number != seq_inc) ||
                      (hdr.source_id != cur.source) ||
                      (hdr.time_stamp < cur.time_last);

  always_comb begin
    cur_next        = cur;
    continuing_next = continuing;
    verdict         = VERDICT_IN_PROCESS;
    priority if (hdr.packet_length == 16'd0) begin
      verdict = VERDICT_IN_PROCESS;
    end else if (bad_header) begin
      verdict = VERDICT_INVALID;
    end else if (!continuing) begin
      cur_next.seq_last  = hdr.sequence_number;
      cur_next.time_last = hdr.time_stamp;
      cur_next.source    = hdr.source_id;
      cur_next.packets   = count_inc;
      continuing_next    = 1'b1;
      verdict            = VERDICT_IN_PROCESS;
    end else begin
      cur_next.seq_last = seq_inc;
      if (mismatch) begin
        verdict = VERDICT_INVALID;
      end else begin
        cur_next.time_last = hdr.time_stamp;
        cur_next.packets   = count_inc;
        verdict = (count_inc < cfg.packets_needed) ? VERDICT_IN_PROCESS : VERDICT_RTP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      continuing   <= 1'b0;
      dir_state[0] <= '0;
      dir_state[1] <= '0;
    end else if (advance) begin
      continuing                     <= continuing_next;
      dir_state[hdr.from_initiator]  <= cur_next;
    end
  end

endmodule

FILE: hw/rtl/rtp_flow_header_validator_unit.sv
// Top level of the RTP flow header validator.
//
// Takes one decoded UDP packet header per transaction on hdr and returns one
// verdict per header on res, in order: in process, invalid, or RTP detected.
// Configuration (max payload type, packets needed) is written on cfg, which
// is always ready; write it only while no header is in flight.
//
// A verdict becomes valid in the result register after its header is
// accepted: the header lands in an input register, the flow state is
// checked and updated in one pass from that register into the result
// register. One header per cycle is sustained while res is ready; the
// input register and the result register hold one transaction each, so
// a header is taken into an empty input register while a verdict waits.
//
// Reset clears both pipeline stages, the flow state and restores the
// configuration defaults (34 and 3). When res stalls, the verdict holds,
// the input register holds its header and hdr deasserts ready once full.
module rtp_flow_header_validator_unit import rtpv_pkg::*; (
  input logic           clk,
  input logic           rst,
  rtpv_hdr_if.sink      hdr,
  rtpv_cfg_if.sink      cfg,
  rtpv_res_if.source    res
);

  cfg_t     cfg_q;
  header_t  hdr_q;
  logic     in_valid;
  logic     out_valid;
  verdict_t verdict_q;
  verdict_t verdict_comb;
  logic     advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign hdr.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;
  assign res.valid   = out_valid;
  assign res.verdict = verdict_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.max_payload_type <= MAX_PT_RESET;
      cfg_q.packets_needed   <= NEEDED_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MAX_PAYLOAD_TYPE) begin
        cfg_q.max_payload_type <= cfg.data[6:0];
      end else if (cfg.index == CFG_PACKETS_NEEDED) begin
        cfg_q.packets_needed <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (hdr.valid && hdr.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      hdr_q.packet_length   <= hdr.packet_length;
      hdr_q.from_initiator  <= hdr.from_initiator;
      hdr_q.rtp_version     <= hdr.rtp_version;
      hdr_q.payload_kind    <= hdr.payload_kind;
      hdr_q.sequence_number <= hdr.sequence_number;
      hdr_q.time_stamp      <= hdr.time_stamp;
      hdr_q.source_id       <= hdr.source_id;
    end
    if (advance) begin
      verdict_q <= verdict_comb;
    end
  end

  rtpv_flow u_flow (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .hdr     (hdr_q),
    .cfg     (cfg_q),
    .verdict (verdict_comb)
  );

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("checked header did not reach the result register");

  a_empty_in_process: assert property (@(posedge clk) disable iff (rst)
    advance && (hdr_q.packet_length == 16'd0) |=> (res.verdict == VERDICT_IN_PROCESS))
    else $error("empty packet did not give in-process");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !hdr.ready |-> (in_valid && out_valid && !res.ready))
    else $error("header channel stalled without a full pipeline");

endmodule
